[hw/rtl/uts_pkg.sv]
// Shared types, byte codes and helpers of the UTF-8 text sanitizer.
`default_nettype none

package uts_pkg;

    // Input kinds carried in s_tuser
    localparam logic OP_DATA = 1'b0;
    localparam logic OP_END  = 1'b1;

    // Byte codes
    localparam logic [7:0] B_BEL   = 8'h07;
    localparam logic [7:0] B_TAB   = 8'h09;
    localparam logic [7:0] B_LF    = 8'h0A;
    localparam logic [7:0] B_CR    = 8'h0D;
    localparam logic [7:0] B_ESC   = 8'h1B;
    localparam logic [7:0] B_SPACE = 8'h20;
    localparam logic [7:0] B_CSI_FIN_LO = 8'h40;
    localparam logic [7:0] B_LBRACK = 8'h5B;
    localparam logic [7:0] B_BSLASH = 8'h5C;
    localparam logic [7:0] B_RBRACK = 8'h5D;
    localparam logic [7:0] B_CSI_FIN_HI = 8'h7E;
    localparam logic [7:0] B_DEL   = 8'h7F;
    localparam logic [7:0] B_8F    = 8'h8F;
    localparam logic [7:0] B_90    = 8'h90;
    localparam logic [7:0] B_9F    = 8'h9F;
    localparam logic [7:0] B_A0    = 8'hA0;
    localparam logic [7:0] B_C2    = 8'hC2;
    localparam logic [7:0] B_DF    = 8'hDF;
    localparam logic [7:0] B_E0    = 8'hE0;
    localparam logic [7:0] B_ED    = 8'hED;
    localparam logic [7:0] B_EF    = 8'hEF;
    localparam logic [7:0] B_F0    = 8'hF0;
    localparam logic [7:0] B_F4    = 8'hF4;

    // Command queue geometry
    localparam int QDepth = 4;
    localparam int QAw    = $clog2(QDepth);

    // One command per accepted item that gives a beat: a run of U+FFFD,
    // then a tail of bytes or the closing end-of-text beat.
    typedef struct packed {
        logic [1:0]      fffd_cnt;
        logic [2:0]      tail_len;
        logic            done;
        logic [3:0][7:0] tail;
    } cmd_t;

    // Bytes of U+FFFD in UTF-8
    function automatic logic [7:0] fffd_byte(input logic [1:0] idx);
        logic [7:0] r;
        case (idx)
            2'd0:    r = 8'hEF;
            2'd1:    r = 8'hBF;
            default: r = 8'hBD;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/utf8_text_sanitizer.sv]
// Top level of the UTF-8 text sanitizer: front, command queue and back part.
//
// Usage:
//   Input beats arrive on s_tvalid/s_tready with s_tdata = raw byte and
//   s_tuser = kind (0 data byte, 1 end of text). Each accepted beat yields
//   zero to ten output beats on m_tvalid/m_tready: m_tdata = sanitized byte,
//   m_tuser[0] = byte valid, m_tuser[1] = text done, and m_tlast marks the
//   last beat caused by one input beat. An input that yields nothing gives no beat.
// Path: the command of an accepted input is written into the queue; its first
//   output beat is then loaded from the queue head into the output register,
//   which drives m_tvalid, m_tdata, m_tuser and m_tlast.
// Throughput: one input beat per cycle while each gives at most one output
//   beat and m_tready stays high. An input that gives several beats (three
//   per U+FFFD, or a completed multibyte character) holds the back part until
//   they are all out; the four-entry command queue keeps the front accepting
//   meanwhile, and s_tready drops only when that queue is full.
// Reset: rst_n clears escape mode, the CR mark, the held count, the queue
//   and the output register; the block is ready right after reset.
// Stall: while m_tready is low the output beat holds, the queue fills,
//   and then s_tready drops until room frees up.
`default_nettype none

module utf8_text_sanitizer
    import uts_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] data_byte
    input  wire logic       s_tuser,   // [0] opcode
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // [7:0] out_byte
    output logic [1:0]      m_tuser,   // [0] byte_valid, [1] text_done
    output logic            m_tlast    // last beat caused by one input beat
);

    // Command path between front and back
    logic push;
    cmd_t push_cmd;
    logic q_full;
    logic q_nonempty;
    logic q_pop;
    cmd_t q_head;

    // Classify each input beat and advance the sanitizer state
    uts_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .push     (push),
        .cmd      (push_cmd)
    );

    // Decouple front and back so each can stall on its own
    uts_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .nonempty (q_nonempty),
        .pop      (q_pop),
        .head     (q_head)
    );

    // Expand commands into output beats, one per cycle while the receiver takes them
    uts_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_nonempty (q_nonempty),
        .q_head     (q_head),
        .q_pop      (q_pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

endmodule

`default_nettype wire

[hw/rtl/uts_front.sv]
// Front part: escape, line-end and UTF-8 state; turns each item into a command.
`default_nettype none

module uts_front
    import uts_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,
    input  wire logic       s_tuser,
    input  wire logic       q_full,
    output logic            push,
    output cmd_t            cmd
);

    typedef enum logic [2:0] {
        MODE_NORMAL  = 3'd0,
        MODE_ESC     = 3'd1,
        MODE_CSI     = 3'd2,
        MODE_OSC     = 3'd3,
        MODE_OSC_ESC = 3'd4
    } esc_mode_t;

    esc_mode_t       mode_reg, mode_next;
    logic            cr_reg, cr_next;
    logic [1:0]      held_cnt_reg, held_cnt_next;
    logic [2:0]      seq_len_reg, seq_len_next;
    logic [2:0][7:0] held_reg, held_next;

    logic       accept;
    logic [7:0] b;
    logic       cont;
    logic       fresh;

    assign s_tready = ~q_full;
    assign accept   = s_tvalid & s_tready;
    assign b        = s_tdata;

    // Does b continue the held sequence (second-byte range limits included)
    always_comb
    begin
        cont = (b[7:6] == 2'b10);
        if (held_cnt_reg == 2'd1)
        begin
            if ((held_reg[0] == B_E0 && b < B_A0) || (held_reg[0] == B_ED && b > B_9F) ||
                (held_reg[0] == B_F0 && b < B_90) || (held_reg[0] == B_F4 && b > B_8F))
            begin
                cont = 1'b0;
            end
        end
    end

    always_comb
    begin
        mode_next     = mode_reg;
        cr_next       = cr_reg;
        held_cnt_next = held_cnt_reg;
        seq_len_next  = seq_len_reg;
        held_next     = held_reg;
        fresh         = 1'b0;
        cmd.fffd_cnt  = 2'd0;
        cmd.tail_len  = 3'd0;
        cmd.done      = 1'b0;
        cmd.tail      = {b, held_reg[2], held_reg[1], held_reg[0]};

        if (s_tuser == OP_END)
        begin
            cmd.fffd_cnt  = held_cnt_reg;
            cmd.tail_len  = 3'd1;
            cmd.done      = 1'b1;
            mode_next     = MODE_NORMAL;
            cr_next       = 1'b0;
            held_cnt_next = 2'd0;
            seq_len_next  = 3'd0;
        end
        else
        begin
            cr_next = 1'b0;
            unique case (mode_reg)
                MODE_ESC:
                begin
                    if (b == B_LBRACK)
                        mode_next = MODE_CSI;
                    else if (b == B_RBRACK)
                        mode_next = MODE_OSC;
                    else
                        mode_next = MODE_NORMAL;
                end
                MODE_CSI:
                begin
                    if (b >= B_CSI_FIN_LO && b <= B_CSI_FIN_HI)
                        mode_next = MODE_NORMAL;
                end
                MODE_OSC_ESC:
                begin
                    if (b == B_BSLASH || b == B_BEL)
                        mode_next = MODE_NORMAL;
                    else if (b == B_ESC)
                        mode_next = MODE_OSC_ESC;
                    else
                        mode_next = MODE_OSC;
                end
                MODE_OSC:
                begin
                    if (b == B_BEL)
                        mode_next = MODE_NORMAL;
                    else if (b == B_ESC)
                        mode_next = MODE_OSC_ESC;
                end
                default:
                begin
                    mode_next = MODE_NORMAL;
                    if (held_cnt_reg == 2'd0)
                    begin
                        fresh = 1'b1;
                    end
                    else if (seq_len_reg >= 3'd2 && cont)
                    begin
                        if ({1'b0, held_cnt_reg} + 3'd1 >= seq_len_reg)
                        begin
                            // complete sequence; drop C1 code points
                            if (!(held_reg[0] == B_C2 && b <= B_9F))
                            begin
                                cmd.tail[held_cnt_reg] = b;
                                cmd.tail_len = {1'b0, held_cnt_reg} + 3'd1;
                            end
                            held_cnt_next = 2'd0;
                            seq_len_next  = 3'd0;
                        end
                        else
                        begin
                            held_next[held_cnt_reg] = b;
                            held_cnt_next = held_cnt_reg + 2'd1;
                        end
                    end
                    else
                    begin
                        // broken sequence: one U+FFFD per held byte
                        cmd.fffd_cnt  = held_cnt_reg;
                        held_cnt_next = 2'd0;
                        seq_len_next  = 3'd0;
                        fresh         = 1'b1;
                    end

                    if (fresh)
                    begin
                        if (b == B_ESC)
                        begin
                            mode_next = MODE_ESC;
                        end
                        else if (b == B_CR)
                        begin
                            cmd.tail[0]  = B_LF;
                            cmd.tail_len = 3'd1;
                            cr_next      = 1'b1;
                        end
                        else if (b <= B_DEL)
                        begin
                            if (b == B_LF)
                            begin
                                if (!cr_reg)
                                begin
                                    cmd.tail[0]  = b;
                                    cmd.tail_len = 3'd1;
                                end
                            end
                            else if (b == B_TAB || (b >= B_SPACE && b != B_DEL))
                            begin
                                cmd.tail[0]  = b;
                                cmd.tail_len = 3'd1;
                            end
                        end
                        else
                        begin
                            held_next[0]  = b;
                            held_cnt_next = 2'd1;
                            if (b >= B_C2 && b <= B_DF)
                                seq_len_next = 3'd2;
                            else if (b >= B_E0 && b <= B_EF)
                                seq_len_next = 3'd3;
                            else if (b >= B_F0 && b <= B_F4)
                                seq_len_next = 3'd4;
                            else
                                seq_len_next = 3'd1;
                        end
                    end
                end
            endcase
        end
    end

    // Skip items that give no beat
    assign push = accept & ((cmd.fffd_cnt != 2'd0) | (cmd.tail_len != 3'd0));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_NORMAL;
            cr_reg       <= 1'b0;
            held_cnt_reg <= 2'd0;
            seq_len_reg  <= 3'd0;
        end
        else if (accept)
        begin
            mode_reg     <= mode_next;
            cr_reg       <= cr_next;
            held_cnt_reg <= held_cnt_next;
            seq_len_reg  <= seq_len_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            held_reg <= held_next;
    end

    a_held_only_normal: assert property (@(posedge clk) disable iff (!rst_n)
        held_cnt_reg != 2'd0 |-> mode_reg == MODE_NORMAL)
        else $error("bytes held outside normal text mode");

    a_bad_lead_single: assert property (@(posedge clk) disable iff (!rst_n)
        seq_len_reg == 3'd1 |-> held_cnt_reg == 2'd1)
        else $error("invalid lead byte held with others");

endmodule

`default_nettype wire

[hw/rtl/uts_queue.sv]
// Short command queue between the front and back parts.
`default_nettype none

module uts_queue
    import uts_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  cmd_t      push_cmd,
    output logic      full,
    output logic      nonempty,
    input  wire logic pop,
    output cmd_t      head
);

    localparam logic [QAw:0] DepthCnt = (QAw + 1)'(QDepth);

    cmd_t           mem [QDepth];
    logic [QAw-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QAw:0]   count_reg, count_next;

    assign full     = (count_reg == DepthCnt);
    assign nonempty = (count_reg != '0);
    assign head     = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_cmd;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full && !pop))
        else $error("command queue overflow");

endmodule

`default_nettype wire

[hw/rtl/uts_back.sv]
// Back part: expands queued commands into output beats through an output register.
`default_nettype none

module uts_back
    import uts_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        q_nonempty,
    input  cmd_t             q_head,
    output logic             q_pop,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,
    output logic [1:0]       m_tuser,
    output logic             m_tlast
);

    logic       m_tvalid_reg;
    logic [7:0] m_tdata_reg;
    logic [1:0] m_tuser_reg;
    logic       m_tlast_reg;

    logic [1:0] fffd_idx_reg, sub_reg, tail_idx_reg;

    logic       load;
    logic       in_fffd;
    logic [7:0] beat_byte;
    logic [1:0] beat_user;
    logic       beat_last;

    assign load    = q_nonempty & (~m_tvalid_reg | m_tready);
    assign in_fffd = fffd_idx_reg < q_head.fffd_cnt;

    always_comb
    begin
        if (in_fffd)
        begin
            beat_byte = fffd_byte(sub_reg);
            beat_user = 2'b01;
            beat_last = (fffd_idx_reg == q_head.fffd_cnt - 2'd1) && (sub_reg == 2'd2) &&
                        (q_head.tail_len == 3'd0);
        end
        else
        begin
            if (q_head.done)
            begin
                beat_byte = 8'h00;
                beat_user = 2'b10;
            end
            else
            begin
                beat_byte = q_head.tail[tail_idx_reg];
                beat_user = 2'b01;
            end
            beat_last = ({1'b0, tail_idx_reg} == q_head.tail_len - 3'd1);
        end
    end

    assign q_pop = load & beat_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
            fffd_idx_reg <= 2'd0;
            sub_reg      <= 2'd0;
            tail_idx_reg <= 2'd0;
        end
        else
        begin
            if (load)
            begin
                m_tvalid_reg <= 1'b1;
                if (beat_last)
                begin
                    fffd_idx_reg <= 2'd0;
                    sub_reg      <= 2'd0;
                    tail_idx_reg <= 2'd0;
                end
                else if (in_fffd)
                begin
                    if (sub_reg == 2'd2)
                    begin
                        sub_reg      <= 2'd0;
                        fffd_idx_reg <= fffd_idx_reg + 2'd1;
                    end
                    else
                    begin
                        sub_reg <= sub_reg + 2'd1;
                    end
                end
                else
                begin
                    tail_idx_reg <= tail_idx_reg + 2'd1;
                end
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            m_tdata_reg <= beat_byte;
            m_tuser_reg <= beat_user;
            m_tlast_reg <= beat_last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    a_done_beat_shape: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[1] |-> !m_tuser[0] && m_tlast && m_tdata == 8'h00)
        else $error("end-of-text beat malformed");

endmodule

`default_nettype wire

[bench/tb_utf8_text_sanitizer.sv]
// Self-checking testbench of the UTF-8 text sanitizer: predictor, scoreboard and stream drivers.
`default_nettype none

module tb_utf8_text_sanitizer
    import uts_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    // Longest run of cycles with no beat on either side before the run is abandoned
    localparam int unsigned QUIET_LIMIT  = 4000;
    // Longest sender gap, in cycles
    localparam int unsigned MAX_GAP      = 40;
    // Settle time after the last expected beat: covers the output register and the queue
    localparam int unsigned DRAIN_CYCLES = 10;
    // Input beats per idling phase, roughly
    localparam int unsigned PHASE_ITEMS  = 118;
    localparam int unsigned NUM_PHASES   = 4;

    // Escape parser states of the predictor
    typedef enum logic [2:0] {
        MODE_TEXT,
        MODE_AFTER_ESC,
        MODE_IN_CSI,
        MODE_IN_OSC,
        MODE_OSC_AFTER_ESC
    } esc_mode_t;

    // One output beat as the block should present it
    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       text_done;
        logic       last;
    } out_beat_t;

    // One input beat: kind and raw byte
    typedef struct packed {
        logic       op;
        logic [7:0] data;
    } in_item_t;

    // Tracks sanitizer state, predicts the beats of each accepted input and
    // checks the output stream against them in order.
    class sanitizer_scoreboard;
        esc_mode_t   mode;
        bit          cr_seen;
        logic [7:0]  seq_buf [3];
        int unsigned seq_held;
        int unsigned seq_len;
        out_beat_t   expected_beats [$];
        out_beat_t   step_beats [$];
        int unsigned fail_count;
        int unsigned inputs_seen;
        int unsigned beats_seen;
        int unsigned texts_closed;
        int unsigned replacements;

        function new();
            mode         = MODE_TEXT;
            cr_seen      = 1'b0;
            seq_held     = 0;
            seq_len      = 0;
            foreach (seq_buf[i]) seq_buf[i] = 8'h00;
            fail_count   = 0;
            inputs_seen  = 0;
            beats_seen   = 0;
            texts_closed = 0;
            replacements = 0;
        endfunction

        function void emit(logic [7:0] b);
            out_beat_t ob;
            ob.out_byte   = b;
            ob.byte_valid = 1'b1;
            ob.text_done  = 1'b0;
            ob.last       = 1'b0;
            step_beats    = {step_beats, ob};
        endfunction

        // U+FFFD in UTF-8
        function void emit_replacement();
            emit(B_EF);
            emit(8'hBF);
            emit(8'hBD);
            replacements++;
        endfunction

        function void flush_seq();
            repeat (seq_held) emit_replacement();
            seq_held = 0;
            seq_len  = 0;
        endfunction

        // Byte in text mode with no sequence pending
        function void start_byte(logic [7:0] b, bit prev_cr);
            if (b == B_ESC)
            begin
                mode = MODE_AFTER_ESC;
            end
            else if (b == B_CR)
            begin
                emit(B_LF);
                cr_seen = 1'b1;
            end
            else if (b <= B_DEL)
            begin
                if (b == B_LF)
                begin
                    if (!prev_cr) emit(b);
                end
                else if (b == B_TAB || (b >= B_SPACE && b != B_DEL))
                begin
                    emit(b);
                end
            end
            else
            begin
                seq_buf[0] = b;
                seq_held   = 1;
                if (b >= B_C2 && b <= B_DF)
                    seq_len = 2;
                else if (b >= B_E0 && b <= B_EF)
                    seq_len = 3;
                else if (b >= B_F0 && b <= B_F4)
                    seq_len = 4;
                else
                    seq_len = 1;
            end
        endfunction

        // Strict continuation test, with the second-byte limits of E0, ED, F0, F4
        function bit continues_seq(logic [7:0] b);
            if (b[7:6] != 2'b10) return 1'b0;
            if (seq_held == 1)
            begin
                if (seq_buf[0] == B_E0 && b < B_A0) return 1'b0;
                if (seq_buf[0] == B_ED && b > B_9F) return 1'b0;
                if (seq_buf[0] == B_F0 && b < B_90) return 1'b0;
                if (seq_buf[0] == B_F4 && b > B_8F) return 1'b0;
            end
            return 1'b1;
        endfunction

        function void text_byte(logic [7:0] b, bit prev_cr);
            if (seq_held == 0)
            begin
                start_byte(b, prev_cr);
                return;
            end
            if (seq_len >= 2 && continues_seq(b))
            begin
                if (seq_held + 1 >= seq_len)
                begin
                    // C1 code points complete silently
                    if (!(seq_buf[0] == B_C2 && b <= B_9F))
                    begin
                        for (int i = 0; i < seq_held; i++) emit(seq_buf[i]);
                        emit(b);
                    end
                    seq_held = 0;
                    seq_len  = 0;
                end
                else
                begin
                    seq_buf[seq_held] = b;
                    seq_held++;
                end
                return;
            end
            // Broken sequence: replace what is held, then treat the byte as new
            flush_seq();
            start_byte(b, prev_cr);
        endfunction

        function void note_input(logic op, logic [7:0] b);
            out_beat_t ob;
            bit        prev_cr;
            step_beats.delete();
            inputs_seen++;
            if (op == OP_END)
            begin
                flush_seq();
                ob           = '0;
                ob.text_done = 1'b1;
                step_beats   = {step_beats, ob};
                mode    = MODE_TEXT;
                cr_seen = 1'b0;
                texts_closed++;
            end
            else
            begin
                prev_cr = cr_seen;
                cr_seen = 1'b0;
                case (mode)
                    MODE_AFTER_ESC:
                    begin
                        if (b == B_LBRACK)
                            mode = MODE_IN_CSI;
                        else if (b == B_RBRACK)
                            mode = MODE_IN_OSC;
                        else
                            mode = MODE_TEXT;
                    end
                    MODE_IN_CSI:
                    begin
                        if (b >= B_CSI_FIN_LO && b <= B_CSI_FIN_HI) mode = MODE_TEXT;
                    end
                    MODE_OSC_AFTER_ESC:
                    begin
                        if (b == B_BSLASH || b == B_BEL)
                            mode = MODE_TEXT;
                        else if (b == B_ESC)
                            mode = MODE_OSC_AFTER_ESC;
                        else
                            mode = MODE_IN_OSC;
                    end
                    MODE_IN_OSC:
                    begin
                        if (b == B_BEL)
                            mode = MODE_TEXT;
                        else if (b == B_ESC)
                            mode = MODE_OSC_AFTER_ESC;
                    end
                    default:
                    begin
                        mode = MODE_TEXT;
                        text_byte(b, prev_cr);
                    end
                endcase
            end
            if (step_beats.size() > 0) step_beats[step_beats.size() - 1].last = 1'b1;
            expected_beats = {expected_beats, step_beats};
        endfunction

        task report_mismatch(string what);
            $display("[%0t] MISMATCH at output beat %0d: %s", $realtime, beats_seen, what);
            fail_count++;
        endtask

        task check_beat(logic [7:0] data, logic [1:0] user, logic tlast);
            out_beat_t want;
            beats_seen++;
            if (expected_beats.size() == 0)
            begin
                report_mismatch($sformatf("unexpected beat data=%02h user=%b last=%b",
                                          data, user, tlast));
                return;
            end
            want = expected_beats.pop_front();
            if (data !== want.out_byte)
                report_mismatch($sformatf("out_byte %02h, want %02h", data, want.out_byte));
            if (user[0] !== want.byte_valid)
                report_mismatch($sformatf("byte_valid %b, want %b", user[0], want.byte_valid));
            if (user[1] !== want.text_done)
                report_mismatch($sformatf("text_done %b, want %b", user[1], want.text_done));
            if (tlast !== want.last)
                report_mismatch($sformatf("last %b, want %b", tlast, want.last));
        endtask

        function int unsigned pending();
            return expected_beats.size();
        endfunction
    endclass

    // ------------------------------------------------------------------
    // Block and its stimulus signals; every input is known from time zero
    // ------------------------------------------------------------------
    logic       clk      = 1'b0;
    logic       rst_n    = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;   // [7:0] data_byte
    logic       s_tuser  = OP_DATA; // [0] opcode
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;            // [7:0] out_byte
    logic [1:0] m_tuser;            // [0] byte_valid, [1] text_done
    logic       m_tlast;            // last beat of one input beat

    utf8_text_sanitizer u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    sanitizer_scoreboard sb = new();

    int unsigned tx_idle_pct  = 0;  // chance in 100 that the sender holds off a cycle
    int unsigned rx_stall_pct = 0;  // chance in 100 that the receiver stalls a cycle
    int unsigned quiet_cycles = 0;
    in_item_t    stim_q [$];

    // 2 ns clock
    initial
    begin
        forever #1 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Receiver: draw m_tready afresh at every edge
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(99) >= rx_stall_pct);
    end

    // ------------------------------------------------------------------
    // Monitor: values read here are the ones that stood before the edge,
    // so a beat counts exactly when tvalid and tready were both high.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready) sb.note_input(s_tuser, s_tdata);
            if (m_tvalid && m_tready) sb.check_beat(m_tdata, m_tuser, m_tlast);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
    end

    // Watchdog: abandon the run when neither side has moved for too long
    initial
    begin
        do @(posedge clk); while (quiet_cycles < QUIET_LIMIT);
        $display("[%0t] watchdog: no beat for %0d cycles, %0d beats still expected",
                 $realtime, QUIET_LIMIT, sb.pending());
        $display("CHECKS FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus building
    // ------------------------------------------------------------------
    function automatic void add_byte(logic [7:0] b);
        in_item_t it;
        it.op   = OP_DATA;
        it.data = b;
        stim_q  = {stim_q, it};
    endfunction

    // End of text; the data byte rides along as random junk
    function automatic void add_end();
        in_item_t it;
        it.op   = OP_END;
        it.data = 8'($urandom);
        stim_q  = {stim_q, it};
    endfunction

    // Encode one code point as UTF-8 without checking its range
    function automatic void add_code_point(logic [20:0] cp);
        if (cp < 21'h80)
        begin
            add_byte({1'b0, cp[6:0]});
        end
        else if (cp < 21'h800)
        begin
            add_byte({3'b110, cp[10:6]});
            add_byte({2'b10, cp[5:0]});
        end
        else if (cp < 21'h10000)
        begin
            add_byte({4'b1110, cp[15:12]});
            add_byte({2'b10, cp[11:6]});
            add_byte({2'b10, cp[5:0]});
        end
        else
        begin
            add_byte({5'b11110, cp[20:18]});
            add_byte({2'b10, cp[17:12]});
            add_byte({2'b10, cp[11:6]});
            add_byte({2'b10, cp[5:0]});
        end
    endfunction

    // Short directed opening: controls, every escape form, strict UTF-8 cases
    function automatic void add_directed();
        add_byte(8'h41);
        add_byte(B_TAB);
        add_byte(B_CR);                 // CR then LF: a single LF comes out
        add_byte(B_LF);
        add_byte(B_DEL);                // dropped
        add_byte(B_ESC);                // CSI ended by its highest final byte
        add_byte(B_LBRACK);
        add_byte(B_CSI_FIN_HI);
        add_byte(B_ESC);                // OSC with a stray ESC, ended by ESC backslash
        add_byte(B_RBRACK);
        add_byte(B_ESC);
        add_byte(8'h41);
        add_byte(B_ESC);
        add_byte(B_BSLASH);
        add_byte(B_ESC);                // OSC ended by BEL
        add_byte(B_RBRACK);
        add_byte(B_BEL);
        add_byte(B_ESC);                // ESC plus one plain byte
        add_byte(8'h63);
        add_byte(B_C2);                 // C1 control, dropped
        add_byte(8'h80);
        add_byte(B_E0);                 // overlong three-byte form
        add_byte(8'h80);
        add_byte(B_ED);                 // surrogate
        add_byte(B_A0);
        add_byte(B_F4);                 // above U+10FFFF
        add_byte(B_90);
        add_code_point(21'h20AC);       // valid three-byte character
        add_byte(8'hFF);                // cannot start a sequence; flushed at end
        add_end();
    endfunction

    // One random token: mostly well-formed text and escapes, some noise
    function automatic void add_token();
        int unsigned pick;
        int unsigned n;
        pick = $urandom_range(99);
        if (pick < 30)
        begin
            n = $urandom_range(6, 1);
            repeat (n) add_byte(8'($urandom_range(8'h7E, 8'h20)));
        end
        else if (pick < 50)
        begin
            case ($urandom_range(2))
                0:       add_code_point(21'($urandom_range(21'h7FF, 21'h80)));
                1:       add_code_point(21'($urandom_range(21'hFFFF, 21'h800)));
                default: add_code_point(21'($urandom_range(21'h10FFFF, 21'h10000)));
            endcase
        end
        else if (pick < 58)
        begin
            add_byte(B_ESC);
            add_byte(B_LBRACK);
            n = $urandom_range(4);
            repeat (n) add_byte(8'($urandom_range(8'h3F, 8'h20)));
            add_byte(8'($urandom_range(B_CSI_FIN_HI, B_CSI_FIN_LO)));
        end
        else if (pick < 64)
        begin
            add_byte(B_ESC);
            add_byte(B_RBRACK);
            n = $urandom_range(6);
            repeat (n)
            begin
                if ($urandom_range(5) == 0)
                begin
                    add_byte(B_ESC);
                    add_byte(8'($urandom_range(8'h7E, 8'h20)));
                end
                else
                begin
                    add_byte(8'($urandom_range(8'h7E, 8'h20)));
                end
            end
            if ($urandom_range(1) == 0)
            begin
                add_byte(B_BEL);
            end
            else
            begin
                add_byte(B_ESC);
                add_byte(B_BSLASH);
            end
        end
        else if (pick < 68)
        begin
            add_byte(B_ESC);
            add_byte(8'($urandom));
        end
        else if (pick < 76)
        begin
            case ($urandom_range(3))
                0:       add_byte(B_CR);
                1:       add_byte(B_LF);
                2:
                begin
                    add_byte(B_CR);
                    add_byte(B_LF);
                end
                default: add_byte(B_TAB);
            endcase
        end
        else if (pick < 84)
        begin
            // possibly broken sequence: any high lead, zero to three continuations
            add_byte(8'($urandom_range(8'hFF, 8'h80)));
            n = $urandom_range(3);
            repeat (n) add_byte(8'($urandom_range(8'hBF, 8'h80)));
        end
        else if (pick < 95)
        begin
            add_byte(8'($urandom));
        end
        else
        begin
            add_end();
        end
    endfunction

    // ------------------------------------------------------------------
    // Sender: optional gap, then hold the beat until it is taken
    // ------------------------------------------------------------------
    task automatic send_item(in_item_t it);
        int unsigned gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < tx_idle_pct) gap++;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= it.op;
        s_tdata  <= it.data;
        do @(posedge clk); while (!s_tready);
    endtask

    // Hold off until every expected beat is out, then let the pipe settle
    task automatic wait_drained();
        while (sb.pending() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            // Idling per phase: none, sender idle, receiver stalling, both
            case (phase)
                0:
                begin
                    tx_idle_pct  = 0;
                    rx_stall_pct = 0;
                end
                1:
                begin
                    tx_idle_pct  = 74;
                    rx_stall_pct = 0;
                end
                2:
                begin
                    tx_idle_pct  = 0;
                    rx_stall_pct = 74;
                end
                default:
                begin
                    tx_idle_pct  = 20;
                    rx_stall_pct = 20;
                end
            endcase
            stim_q.delete();
            if (phase == 0) add_directed();
            while (stim_q.size() < PHASE_ITEMS) add_token();
            add_end();
            foreach (stim_q[i]) send_item(stim_q[i]);
            s_tvalid <= 1'b0;
            wait_drained();
        end

        if (sb.pending() != 0)
            sb.report_mismatch($sformatf("%0d expected beats never came", sb.pending()));

        $display("Covered %0d input beats in %0d texts over %0d idling phases.",
                 sb.inputs_seen, sb.texts_closed, NUM_PHASES);
        $display("Checked %0d output beats, %0d U+FFFD replacements, %0d mismatches.",
                 sb.beats_seen, sb.replacements, sb.fail_count);
        if (sb.fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

`default_nettype wire
